@@ hw/rtl/rect_polar_converter_unit_defines.svh @@
// Assertion macros for the rect/polar converter checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef RECT_POLAR_CONVERTER_UNIT_DEFINES_SVH
`define RECT_POLAR_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rpc_pkg.sv @@
// Shared types, constants and the arctangent table of the rect/polar converter.
// No dependencies.
package rpc_pkg;

  localparam int ITER_DEFAULT = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int IN_W         = 16;
  localparam int MAG_W        = 17;
  localparam int FRAC_W       = 16;
  localparam int XY_W         = 36;
  localparam int Z_W          = 32;
  localparam int GAIN_W       = 31;
  localparam int GAIN_FRAC    = 30;
  localparam int SPLIT        = 17;
  localparam int MAG_MAX      = 46341;

  localparam logic signed [GAIN_W-1:0] INV_GAIN = 31'sd652032874;
  localparam logic [Z_W-1:0]           PI_Z     = 32'h8000_0000;

  localparam logic ACT_TO_POLAR = 1'b0;
  localparam logic ACT_TO_RECT  = 1'b1;

  typedef struct packed {
    logic                   action;
    logic signed [IN_W-1:0] in_first;
    logic signed [IN_W-1:0] in_second;
  } rpc_in_t;

  typedef struct packed {
    logic signed [MAG_W-1:0] out_first;
    logic signed [IN_W-1:0]  out_second;
  } rpc_out_t;

  typedef struct packed {
    logic                   to_rect;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rpc_work_t;

  function automatic logic signed [Z_W-1:0] atan_at(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051E;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2FA;
      15:      v = 32'h0000_517D;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A30;
      19:      v = 32'h0000_0518;
      20:      v = 32'h0000_028C;
      21:      v = 32'h0000_0146;
      22:      v = 32'h0000_00A3;
      23:      v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/rpc_front.sv @@
// Front end: classifies an incoming beat and sets up the CORDIC start vector.
// Depends on rpc_pkg.
module rpc_front (
  input  rpc_pkg::rpc_in_t   in_item,
  output rpc_pkg::rpc_work_t work
);
  import rpc_pkg::*;

  logic signed [XY_W-1:0] first_s;
  logic signed [XY_W-1:0] second_s;
  logic signed [IN_W-1:0] ang;
  logic                   wide;

  assign first_s  = {{(XY_W-IN_W-FRAC_W){in_item.in_first[IN_W-1]}},
                     in_item.in_first, {FRAC_W{1'b0}}};
  assign second_s = {{(XY_W-IN_W-FRAC_W){in_item.in_second[IN_W-1]}},
                     in_item.in_second, {FRAC_W{1'b0}}};

  // angles beyond +-pi/2 fold by pi: flipping the top bit of a binary angle
  assign wide = (in_item.in_second > 16'sd16384) || (in_item.in_second < -16'sd16384);
  assign ang  = wide ? {~in_item.in_second[IN_W-1], in_item.in_second[IN_W-2:0]}
                     : in_item.in_second;

  always_comb begin
    work = '0;
    if (in_item.action == ACT_TO_POLAR) begin
      work.to_rect = ACT_TO_POLAR;
      work.zero    = (in_item.in_first == '0) && (in_item.in_second == '0);
      if (in_item.in_first[IN_W-1]) begin
        work.x = -first_s;
        work.y = -second_s;
        work.z = PI_Z;
      end else begin
        work.x = first_s;
        work.y = second_s;
        work.z = '0;
      end
    end else begin
      work.to_rect = ACT_TO_RECT;
      work.zero    = 1'b0;
      work.x       = wide ? -first_s : first_s;
      work.y       = '0;
      work.z       = {ang, {(Z_W-IN_W){1'b0}}};
    end
  end

endmodule

@@ hw/rtl/rpc_queue.sv @@
// Short queue between front and back; the head is read out into a register.
// Depends on rpc_pkg.
module rpc_queue #(
  parameter int DEPTH = rpc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rpc_pkg::rpc_work_t push_data,
  output logic               full,
  output logic               head_vld,
  output rpc_pkg::rpc_work_t head
);
  import rpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpc_work_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             head_vld_r;
  rpc_work_t        head_r;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign wr_en = push && !full;
  assign rd_en = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (rd_en) begin
      head_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      head_vld_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
      head_vld_r <= rd_en;
    end
  end

  assign head_vld = head_vld_r;
  assign head     = head_r;

endmodule

@@ hw/rtl/rpc_back.sv @@
// Back end: unrolled CORDIC stages, split gain multiply, rounding and saturation.
// Depends on rpc_pkg.
module rpc_back #(
  parameter int ITERATIONS = rpc_pkg::ITER_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  rpc_pkg::rpc_work_t in_work,
  output logic               out_valid,
  output rpc_pkg::rpc_out_t  out_data
);
  import rpc_pkg::*;

  localparam int HI_W  = XY_W - SPLIT;
  localparam int PH_W  = HI_W + GAIN_W;
  localparam int PL_W  = SPLIT + 1 + GAIN_W;
  localparam int SUM_W = XY_W + GAIN_W + 1;
  localparam int SHIFT = GAIN_FRAC + FRAC_W;
  localparam int M_W   = SUM_W - SHIFT;

  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (SHIFT - 1);

  function automatic rpc_work_t cordic_step(input rpc_work_t w, input int sh);
    rpc_work_t              r;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   add_dir;
    r       = w;
    x       = w.x;
    y       = w.y;
    z       = w.z;
    dx      = y >>> sh;
    dy      = x >>> sh;
    add_dir = w.to_rect ? z[Z_W-1] : !y[XY_W-1];
    if (add_dir) begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + atan_at(sh);
    end else begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - atan_at(sh);
    end
    return r;
  endfunction

  function automatic logic signed [IN_W-1:0] sat16(input logic signed [M_W-1:0] v);
    logic signed [IN_W-1:0] r;
    if (v > M_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -M_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[IN_W-1:0];
    end
    return r;
  endfunction

  rpc_work_t stg_r [1:ITERATIONS];
  logic      vld_r [1:ITERATIONS];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    rpc_work_t src;
    logic      src_vld;
    rpc_work_t stg_nxt;
    if (i == 0) begin : g_first
      assign src     = in_work;
      assign src_vld = in_vld;
    end else begin : g_rest
      assign src     = stg_r[i];
      assign src_vld = vld_r[i];
    end
    assign stg_nxt = cordic_step(src, i);
    always_ff @(posedge clk) begin
      stg_r[i+1] <= stg_nxt;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= src_vld;
      end
    end
  end

  // gain removal: each of x and y split into high and low partial products
  rpc_work_t              last;
  logic signed [XY_W-1:0] xc;
  logic signed [XY_W-1:0] yl;
  logic signed [HI_W-1:0] x_hi, y_hi;
  logic signed [SPLIT:0]  x_lo, y_lo;

  logic signed [PH_W-1:0] xh_prod_r, yh_prod_r;
  logic signed [PL_W-1:0] xl_prod_r, yl_prod_r;
  logic                   mul_vld_r;
  logic                   mul_rect_r;
  logic                   mul_zero_r;
  logic [Z_W-1:0]         mul_z_r;

  assign last = stg_r[ITERATIONS];
  assign yl   = last.y;
  assign xc   = (!last.to_rect && last.x[XY_W-1]) ? '0 : last.x;
  assign x_hi = xc[XY_W-1:SPLIT];
  assign y_hi = yl[XY_W-1:SPLIT];
  assign x_lo = {1'b0, xc[SPLIT-1:0]};
  assign y_lo = {1'b0, yl[SPLIT-1:0]};

  always_ff @(posedge clk) begin
    xh_prod_r  <= x_hi * INV_GAIN;
    xl_prod_r  <= x_lo * INV_GAIN;
    yh_prod_r  <= y_hi * INV_GAIN;
    yl_prod_r  <= y_lo * INV_GAIN;
    mul_rect_r <= last.to_rect;
    mul_zero_r <= last.zero;
    mul_z_r    <= last.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= vld_r[ITERATIONS];
    end
  end

  logic signed [SUM_W-1:0] x_sum, y_sum;
  logic signed [M_W-1:0]   x_m, y_m;
  logic [Z_W-1:0]          z_rnd;
  rpc_out_t                res;
  rpc_out_t                out_r;
  logic                    out_vld_r;

  assign x_sum = (SUM_W'(xh_prod_r) <<< SPLIT) + SUM_W'(xl_prod_r) + ROUND;
  assign y_sum = (SUM_W'(yh_prod_r) <<< SPLIT) + SUM_W'(yl_prod_r) + ROUND;
  assign x_m   = x_sum[SUM_W-1:SHIFT];
  assign y_m   = y_sum[SUM_W-1:SHIFT];
  assign z_rnd = mul_z_r + Z_W'(32'h8000);

  always_comb begin
    res = '0;
    if (mul_rect_r) begin
      res.out_first  = MAG_W'(sat16(x_m));
      res.out_second = sat16(y_m);
    end else if (!mul_zero_r) begin
      res.out_first  = (x_m > M_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : x_m[MAG_W-1:0];
      res.out_second = z_rnd[Z_W-1:Z_W-IN_W];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= mul_vld_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/rect_polar_converter_unit.sv @@
// Rect/polar converter top: front classifier, queue, pipelined CORDIC back end.
// out_valid follows start via queue, head, stage, multiply, output registers.
// Throughput: one beat per cycle while not busy; the queue pops when nonempty.
// busy reflects a full queue and stays low in steady operation.
// Reset: synchronous, active low; clears the queue and all stage valids.
// Depends on rpc_pkg, rpc_front, rpc_queue, rpc_back.
module rect_polar_converter_unit #(
  parameter int ITERATIONS = rpc_pkg::ITER_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rpc_pkg::rpc_in_t in_data,
  output logic             out_valid,
  output rpc_pkg::rpc_out_t out_data
);
  import rpc_pkg::*;

  rpc_work_t front_work;
  rpc_work_t head;
  logic      head_vld;
  logic      full;

  rpc_front u_front (
    .in_item (in_data),
    .work    (front_work)
  );

  rpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_data (front_work),
    .full      (full),
    .head_vld  (head_vld),
    .head      (head)
  );

  rpc_back #(
    .ITERATIONS (ITERATIONS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (head_vld),
    .in_work   (head),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = full;

endmodule

@@ hw/rtl/rpc_checker.sv @@
// Port-level checker for the rect/polar converter, bound to the top level.
// Depends on rpc_pkg and rect_polar_converter_unit_defines.svh.
`include "rect_polar_converter_unit_defines.svh"

module rpc_checker #(
  parameter int ITERATIONS = rpc_pkg::ITER_DEFAULT
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rpc_pkg::rpc_in_t  in_data,
  input logic              out_valid,
  input rpc_pkg::rpc_out_t out_data
);
  import rpc_pkg::*;

  localparam int LAT = ITERATIONS + 4;

  `RPC_ASSERT_NOW(a_result_has_beat, out_valid, $past(start && !busy, LAT), "result without an input beat")
  `RPC_ASSERT_NOW(a_mag_range, out_valid && ($past(in_data.action, LAT) == ACT_TO_POLAR), !out_data.out_first[MAG_W-1] && (out_data.out_first <= 17'sd46341), "magnitude out of range")
  `RPC_ASSERT_NOW(a_zero_vector, out_valid && ($past(in_data.action, LAT) == ACT_TO_POLAR) && ($past(in_data.in_first, LAT) == '0) && ($past(in_data.in_second, LAT) == '0), (out_data.out_first == '0) && (out_data.out_second == '0), "zero vector not zero")
  `RPC_ASSERT_NOW(a_rect_sat, out_valid && ($past(in_data.action, LAT) == ACT_TO_RECT), out_data.out_first[MAG_W-1] == out_data.out_first[MAG_W-2], "real part beyond 16 bits")
  `RPC_ASSERT_NEXT(a_queue_drains, start && !busy, !busy, "queue backed up")

endmodule

bind rect_polar_converter_unit rpc_checker #(.ITERATIONS(ITERATIONS)) u_rpc_checker (.*);

@@ tb/rect_polar_converter_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for rect_polar_converter_unit: directed corner table, then random beats;
// typed rows: stored values; others: an in-bench fixed-point CORDIC model. Depends on rpc_pkg.
module rect_polar_converter_unit_test;
  import rpc_pkg::*;

  localparam int STEPS = ITER_DEFAULT;
  localparam int RANDOM_BEATS = 1400;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint PI_ANGLE = 64'sd2147483648;
  localparam longint ATAN_Z [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    rpc_in_t  stim;
    logic     typed;
    rpc_out_t want;
  } corner_row_t;

  localparam int CORNER_ROWS = 24;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  rpc_in_t  in_data;
  logic     out_valid;
  rpc_out_t out_data;

  rpc_out_t    pending_results[$];
  int          mismatch_count;
  int          cycle_count;
  corner_row_t corner_rows [CORNER_ROWS];

  rect_polar_converter_unit #(.ITERATIONS(STEPS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // remove CORDIC gain, rounding half up
  function automatic longint drop_gain(input longint v);
    return (v * GAIN_Q30 + (longint'(1) <<< 45)) >>> 46;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic rpc_out_t predict_conversion(input rpc_in_t d);
    longint p, q, x, y, z, dx, dy, m;
    logic [63:0] zr;
    rpc_out_t r;
    p = longint'($signed(d.in_first));
    q = longint'($signed(d.in_second));
    r = '0;
    if (d.action == ACT_TO_POLAR) begin
      if (p == 0 && q == 0) return r;
      x = p * 65536;
      y = q * 65536;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = PI_ANGLE;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_Z[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_Z[i];
        end
      end
      if (x < 0) x = 0;
      m = drop_gain(x);
      if (m > longint'(MAG_MAX)) m = longint'(MAG_MAX);
      zr = z + 64'd32768;
      r.out_first = m[MAG_W-1:0];
      r.out_second = zr[31:16];
    end else begin
      x = p * 65536;
      y = 0;
      if (q > 16384) begin
        q -= 32768;
        x = -x;
      end else if (q < -16384) begin
        q += 32768;
        x = -x;
      end
      z = q * 65536;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_Z[i];
        end else begin
          x += dx; y -= dy; z += ATAN_Z[i];
        end
      end
      m = clip16(drop_gain(x));
      r.out_first = m[MAG_W-1:0];
      m = clip16(drop_gain(y));
      r.out_second = m[IN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pick_operand();
    logic [IN_W-1:0] corners [10] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001,
                                      16'h7FFF, 16'h4000, 16'hC000, 16'h4001, 16'hBFFF};
    if ($urandom_range(99) < 20) return corners[$urandom_range(9)];
    return IN_W'($urandom);
  endfunction

  // one beat: hold start until taken, then log the expected result
  task automatic send_beat(input rpc_in_t d, input logic typed, input rpc_out_t want);
    start <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? want : predict_conversion(d));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    in_data <= rpc_in_t'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rpc_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no beat pending: out_first %0d out_second %0d",
               $signed(out_data.out_first), $signed(out_data.out_second));
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_first !== want.out_first) begin
          $error("out_first expected %0d got %0d",
                 $signed(want.out_first), $signed(out_data.out_first));
          mismatch_count++;
        end
        if (out_data.out_second !== want.out_second) begin
          $error("out_second expected %0d got %0d",
                 $signed(want.out_second), $signed(out_data.out_second));
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rpc_in_t d;
    cycle_count = 0;
    mismatch_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    corner_rows = '{
      '{'{ACT_TO_POLAR, 16'sd0,     16'sd0},     1'b1, '{17'sd0, 16'sd0}},
      '{'{ACT_TO_POLAR, 16'sd32767, 16'sd0},     1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sh8000,  16'sd0},     1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sd0,     16'sd32767}, 1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sd0,     16'sh8000},  1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sh8000,  16'sh8000},  1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sd32767, 16'sd32767}, 1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sd32767, 16'sh8000},  1'b0, '0},
      '{'{ACT_TO_POLAR, -16'sd1,    16'sd0},     1'b0, '0},
      '{'{ACT_TO_POLAR, -16'sd1,    -16'sd1},    1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sd1,     16'sd0},     1'b0, '0},
      '{'{ACT_TO_POLAR, 16'sh8000,  16'sd1},     1'b0, '0},
      '{'{ACT_TO_POLAR, -16'sd5,    16'sd0},     1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd0,     16'sd12345}, 1'b1, '{17'sd0, 16'sd0}},
      '{'{ACT_TO_RECT,  16'sd32767, 16'sd0},     1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd32767, 16'sd16384}, 1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd32767, 16'sd16385}, 1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd32767, -16'sd16384}, 1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd32767, -16'sd16385}, 1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd32767, 16'sh8000},  1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd32767, 16'sd32767}, 1'b0, '0},
      '{'{ACT_TO_RECT,  16'sh8000,  16'sd0},     1'b0, '0},
      '{'{ACT_TO_RECT,  16'sh8000,  16'sh8000},  1'b0, '0},
      '{'{ACT_TO_RECT,  16'sd1,     -16'sd1},    1'b0, '0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_rows[i]) begin
      send_beat(corner_rows[i].stim, corner_rows[i].typed, corner_rows[i].want);
      if ($urandom_range(99) < 27) pause_sender($urandom_range(1, 4));
    end

    // let the pipe drain fully before random traffic
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      d.action = 1'($urandom_range(1));
      d.in_first = pick_operand();
      d.in_second = pick_operand();
      send_beat(d, 1'b0, '0);
      if (n == RANDOM_BEATS / 2) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else if ((n < 400 || n > 800) && $urandom_range(99) < 27) begin
        pause_sender($urandom_range(99) < 10 ? $urandom_range(5, STEPS + 6)
                                             : $urandom_range(1, 3));
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (STEPS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
